// File: rtl/core/rsac_pkg.sv
package rsac_pkg;

  localparam int Slots   = 32;
  localparam int History = 20;
  localparam int Tasks   = 16;
  localparam int Ifaces  = 16;

  localparam int SlotW  = $clog2(Slots);
  localparam int TaskW  = $clog2(Tasks);
  localparam int IfaceW = $clog2(Ifaces);
  localparam int TaddrW = SlotW + TaskW;
  localparam int IaddrW = SlotW + IfaceW;
  localparam int TdepthC = Slots * Tasks;
  localparam int IdepthC = Slots * Ifaces;
  localparam int HistW  = $clog2(History + 1);

  // Interface counters for one slot and interface, packed into one memory word.
  typedef struct packed {
    logic [15:0] rx_packets;
    logic [31:0] rx_bytes;
    logic [15:0] tx_packets;
    logic [31:0] tx_bytes;
    logic [15:0] drops;
  } iface_cnt_t;

  localparam int IfWordW = $bits(iface_cnt_t);

  typedef enum logic [2:0] {
    REQ_SWITCH  = 3'd0,
    REQ_TICK    = 3'd1,
    REQ_PACKET  = 3'd2,
    REQ_CLEAR   = 3'd3,
    REQ_TASK_H  = 3'd4,
    REQ_CPU_H   = 3'd5,
    REQ_IF_READ = 3'd6,
    REQ_UNUSED  = 3'd7
  } req_t;

  localparam logic [1:0] MODE_OFF  = 2'd0;
  localparam logic [1:0] MODE_AUTO = 2'd1;

  localparam int RegRunMode = 0;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [3:0]  task_id;
    logic [31:0] timestamp;
    logic [3:0]  iface_id;
    logic [31:0] byte_count;
    logic        is_receive;
    logic        is_dropped;
    logic [4:0]  slot_age;
  } in_item_t;

  typedef struct packed {
    logic [31:0] value;
    logic [15:0] rx_packets;
    logic [31:0] rx_bytes;
    logic [15:0] tx_packets;
    logic [31:0] tx_bytes;
    logic [15:0] drops;
    logic        accepted;
    logic        last;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load;       // capture the input request
    logic              sweep_en;   // write zero at sweep address
    logic [TaddrW-1:0] sweep_taddr;
    logic              sweep_i;    // also clear interface word
    logic [IaddrW-1:0] sweep_iaddr;
    logic              t_rd;       // read task word at t_raddr
    logic [TaddrW-1:0] t_raddr;
    logic              i_rd;
    logic [IaddrW-1:0] i_raddr;
    logic              t_wr_upd;   // write back updated task word
    logic              i_wr_upd;
    logic              prev_upd;
    logic              slot_inc;
    logic              slot_zero;
    logic              acc_clr;
    logic              acc_add;
    logic              emit;       // build a result into the output register
    logic              emit_last;
  } ctl_cmd_t;

  typedef struct packed {
    in_item_t   item;
    logic [SlotW-1:0] cur_slot;
    logic       out_busy;
  } dp_stat_t;

endpackage

// File: rtl/core/rsac_if.sv
interface rsac_in_if;
  import rsac_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rsac_out_if;
  import rsac_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/rsac_ram.sv
module rsac_ram #(
  parameter int Width = 32,
  parameter int Depth = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// File: rtl/core/rsac_datapath.sv
module rsac_datapath (
  input  logic                clk,
  input  logic                rst,
  input  rsac_pkg::in_item_t  in_data,
  input  logic [1:0]          run_mode,
  input  rsac_pkg::ctl_cmd_t  cmd,
  output rsac_pkg::dp_stat_t  stat,
  rsac_out_if.source          out_ch
);
  import rsac_pkg::*;

  in_item_t         item;
  logic [SlotW-1:0] cur_slot;
  logic [31:0]      prev_tick;
  logic [31:0]      acc;
  logic [31:0]      t_rdata;
  iface_cnt_t       i_rdata;
  logic             i_rsel;   // last interface read was in range
  logic             t_rsel;
  logic             ovalid;
  out_item_t        odata;
  out_item_t        odata_next;

  logic [31:0]      t_new;
  iface_cnt_t       i_new;
  logic [TaddrW-1:0] t_waddr;
  logic [IaddrW-1:0] i_waddr;
  logic              t_we, i_we;
  logic [31:0]       t_wdata;
  iface_cnt_t        i_wdata;
  logic [32:0]       bsum;

  assign t_waddr = cmd.sweep_en ? cmd.sweep_taddr : {cur_slot, item.task_id[TaskW-1:0]};
  assign i_waddr = cmd.sweep_en ? cmd.sweep_iaddr : {cur_slot, item.iface_id[IfaceW-1:0]};
  assign t_we    = (cmd.sweep_en) || cmd.t_wr_upd;
  assign i_we    = (cmd.sweep_en && cmd.sweep_i) || cmd.i_wr_upd;
  assign t_new   = t_rdata + (item.timestamp - prev_tick);
  assign t_wdata = cmd.sweep_en ? 32'd0 : t_new;
  assign i_wdata = cmd.sweep_en ? '0 : i_new;

  always_comb begin
    i_new = i_rdata;
    bsum  = item.is_receive ? {1'b0, i_rdata.rx_bytes} + {1'b0, item.byte_count}
                            : {1'b0, i_rdata.tx_bytes} + {1'b0, item.byte_count};
    if (item.is_receive) begin
      if (i_rdata.rx_packets != 16'hFFFF) i_new.rx_packets = i_rdata.rx_packets + 16'd1;
      i_new.rx_bytes = bsum[32] ? 32'hFFFF_FFFF : bsum[31:0];
    end else begin
      if (i_rdata.tx_packets != 16'hFFFF) i_new.tx_packets = i_rdata.tx_packets + 16'd1;
      i_new.tx_bytes = bsum[32] ? 32'hFFFF_FFFF : bsum[31:0];
    end
    if (item.is_dropped && i_rdata.drops != 16'hFFFF) begin
      i_new.drops = i_rdata.drops + 16'd1;
    end
  end

  always_comb begin
    odata_next = '0;
    odata_next.last = cmd.emit_last;
    unique case (item.req_type)
      REQ_CLEAR: odata_next.accepted = (run_mode == MODE_OFF);
      REQ_TASK_H: odata_next.value = t_rsel ? t_rdata : 32'd0;
      REQ_CPU_H: odata_next.value = acc;
      REQ_IF_READ: begin
        if (i_rsel) begin
          odata_next.rx_packets = i_rdata.rx_packets;
          odata_next.rx_bytes   = i_rdata.rx_bytes;
          odata_next.tx_packets = i_rdata.tx_packets;
          odata_next.tx_bytes   = i_rdata.tx_bytes;
          odata_next.drops      = i_rdata.drops;
        end
      end
      default: odata_next.value = 32'd0;
    endcase
  end

  rsac_ram #(.Width(32), .Depth(TdepthC)) u_tram (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .re(cmd.t_rd), .raddr(cmd.t_raddr), .rdata(t_rdata)
  );

  rsac_ram #(.Width(IfWordW), .Depth(IdepthC)) u_iram (
    .clk(clk), .we(i_we), .waddr(i_waddr), .wdata(i_wdata),
    .re(cmd.i_rd), .raddr(cmd.i_raddr), .rdata(i_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) item <= in_data;
    if (cmd.t_rd) t_rsel <= (32'(item.task_id) < Tasks) || (item.req_type == REQ_CPU_H);
    if (cmd.i_rd) i_rsel <= 32'(item.iface_id) < Ifaces;
    if (cmd.acc_clr) begin
      acc <= 32'd0;
    end else if (cmd.acc_add) begin
      acc <= acc + t_rdata;
    end
    if (cmd.emit) odata <= odata_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_slot  <= '0;
      prev_tick <= 32'd0;
      ovalid    <= 1'b0;
    end else begin
      if (cmd.slot_zero) begin
        cur_slot <= '0;
      end else if (cmd.slot_inc) begin
        cur_slot <= cur_slot + 1'b1;
      end
      if (cmd.prev_upd) prev_tick <= item.timestamp;
      if (cmd.emit) begin
        ovalid <= 1'b1;
      end else if (out_ch.ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  assign out_ch.valid  = ovalid;
  assign out_ch.data   = odata;
  assign stat.item     = item;
  assign stat.cur_slot = cur_slot;
  assign stat.out_busy = ovalid && !out_ch.ready;
endmodule

// File: rtl/core/rsac_ctrl.sv
module rsac_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         run_mode,
  input  rsac_pkg::dp_stat_t stat,
  output rsac_pkg::ctl_cmd_t cmd
);
  import rsac_pkg::*;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DECODE, S_UPD_RD, S_UPD_WR, S_TSWEEP,
    S_H_RD, S_H_WAIT, S_H_ACC, S_H_EMIT, S_AGE, S_I_RD, S_I_WAIT, S_EMIT1
  } state_t;

  state_t            state;
  logic [TaddrW-1:0] sweep_cnt;
  logic [SlotW-1:0]  hslot;
  logic [TaskW-1:0]  tcnt;
  logic [HistW-1:0]  hcnt;
  logic [4:0]        age_cnt;
  logic              sweep_all;
  req_t              req;
  logic [SlotW-1:0]  nslot;

  assign req   = req_t'(stat.item.req_type);
  assign nslot = stat.cur_slot + 1'b1;

  always_comb begin
    cmd = '0;
    in_ready = (state == S_IDLE);
    cmd.load = in_valid && in_ready;
    cmd.sweep_taddr = sweep_cnt;
    cmd.sweep_iaddr = sweep_cnt[IaddrW-1:0];
    cmd.t_raddr = {stat.cur_slot, stat.item.task_id[TaskW-1:0]};
    cmd.i_raddr = {stat.cur_slot, stat.item.iface_id[IfaceW-1:0]};
    unique case (state)
      S_TSWEEP: begin
        cmd.sweep_en = 1'b1;
        cmd.sweep_i  = (TaddrW == IaddrW) || (sweep_cnt < TaddrW'(IdepthC));
      end
      S_DECODE: begin
        cmd.t_rd = (req == REQ_SWITCH) && (run_mode != MODE_OFF);
        cmd.i_rd = (req == REQ_PACKET) && (run_mode != MODE_OFF);
      end
      S_UPD_WR: begin
        cmd.t_wr_upd = (req == REQ_SWITCH) && (32'(stat.item.task_id) < Tasks);
        cmd.prev_upd = (req == REQ_SWITCH);
        cmd.i_wr_upd = (req == REQ_PACKET) && (32'(stat.item.iface_id) < Ifaces);
      end
      S_H_RD: begin
        cmd.t_rd = 1'b1;
        cmd.t_raddr = (req == REQ_CPU_H) ? {hslot, tcnt}
                                         : {hslot, stat.item.task_id[TaskW-1:0]};
      end
      S_H_ACC: cmd.acc_add = 1'b1;
      S_H_EMIT: begin
        cmd.emit = !stat.out_busy;
        cmd.emit_last = (hcnt == HistW'(History - 1));
      end
      S_I_RD: begin
        cmd.i_rd = 1'b1;
        cmd.i_raddr = {hslot, stat.item.iface_id[IfaceW-1:0]};
      end
      S_EMIT1: begin
        cmd.emit = !stat.out_busy;
        cmd.emit_last = 1'b1;
      end
      default: ;
    endcase
    if (state == S_DECODE && req == REQ_TICK && run_mode == MODE_AUTO) cmd.slot_inc = 1'b1;
    if (state == S_DECODE && req == REQ_CLEAR && run_mode == MODE_OFF) cmd.slot_zero = 1'b1;
    if ((state == S_DECODE && (req == REQ_CPU_H)) || (state == S_H_EMIT && !stat.out_busy))
      cmd.acc_clr = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      sweep_cnt <= '0;
      sweep_all <= 1'b1;
      hslot     <= '0;
      tcnt      <= '0;
      hcnt      <= '0;
      age_cnt   <= '0;
    end else begin
      unique case (state)
        S_INIT: state <= S_TSWEEP;
        S_IDLE: if (in_valid) state <= S_DECODE;
        S_DECODE: begin
          hslot <= stat.cur_slot - 1'b1;
          tcnt  <= '0;
          hcnt  <= '0;
          unique case (req)
            REQ_SWITCH, REQ_PACKET:
              state <= (run_mode != MODE_OFF) ? S_UPD_RD : S_IDLE;
            REQ_TICK: begin
              if (run_mode == MODE_AUTO) begin
                sweep_all <= 1'b0;
                sweep_cnt <= {nslot, {TaskW{1'b0}}};
                state <= S_TSWEEP;
              end else begin
                state <= S_IDLE;
              end
            end
            REQ_CLEAR: begin
              if (run_mode == MODE_OFF) begin
                sweep_all <= 1'b1;
                sweep_cnt <= '0;
              end
              state <= S_EMIT1;
            end
            REQ_TASK_H, REQ_CPU_H: state <= S_H_RD;
            REQ_IF_READ: begin
              age_cnt <= stat.item.slot_age;
              state <= S_AGE;
            end
            default: state <= S_IDLE;
          endcase
        end
        S_UPD_RD: state <= S_UPD_WR;
        S_UPD_WR: state <= S_IDLE;
        S_TSWEEP: begin
          sweep_cnt <= sweep_cnt + 1'b1;
          if (sweep_all) begin
            if (sweep_cnt == TaddrW'(TdepthC - 1)) state <= S_IDLE;
          end else if (sweep_cnt[TaskW-1:0] == TaskW'(Tasks - 1)) begin
            state <= S_IDLE;
          end
        end
        S_H_RD: state <= S_H_WAIT;
        S_H_WAIT: state <= (req == REQ_CPU_H) ? S_H_ACC : S_H_EMIT;
        S_H_ACC: begin
          tcnt <= tcnt + 1'b1;
          state <= (tcnt == TaskW'(Tasks - 1)) ? S_H_EMIT : S_H_RD;
        end
        S_H_EMIT: begin
          if (!stat.out_busy) begin
            tcnt  <= '0;
            hcnt  <= hcnt + 1'b1;
            hslot <= hslot - 1'b1;
            state <= (hcnt == HistW'(History - 1)) ? S_IDLE : S_H_RD;
          end
        end
        S_AGE: begin
          if (age_cnt == 5'd0) begin
            state <= S_I_RD;
          end else begin
            age_cnt <= age_cnt - 5'd1;
            hslot <= hslot - 1'b1;
          end
        end
        S_I_RD: state <= S_I_WAIT;
        S_I_WAIT: state <= S_EMIT1;
        S_EMIT1: begin
          if (!stat.out_busy) begin
            // A granted clear sweeps the whole store after reporting.
            state <= (req == REQ_CLEAR && sweep_all && sweep_cnt == '0 && run_mode == MODE_OFF)
                     ? S_TSWEEP : S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE) else $error("ready outside idle");
  a_no_emit_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !stat.out_busy) else $error("emit onto a held result");
  a_sweep_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_TSWEEP && !sweep_all) |-> sweep_cnt[TaddrW-1:TaskW] == stat.cur_slot)
    else $error("slot sweep off the current slot");
`endif
endmodule

// File: rtl/core/ring_slotted_activity_counters.sv
// Channel | Direction | Contents
// in_ch   | sink      | one request: type, task, timestamp, interface, bytes, flags, age
// out_ch  | source    | one result: value, interface counters, accepted, last
// apb     | slave     | run_mode at byte address 0
//
// Counting events step through decode, memory read and write back.
// A slot advance clears the words of one slot in turn; a granted clear sweeps all
// SLOTS*TASKS (512) words, paced by the single write port of the memories.
// After reset the same full clearing pass runs before any request is taken.
// History queries read all task words of HISTORY slots for the cpu sum, one per
// slot for one task; results wait in the output register while the sink stalls.
module ring_slotted_activity_counters (
  input  logic        clk,
  input  logic        rst,
  rsac_in_if.sink     in_ch,
  rsac_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rsac_pkg::*;

  logic [1:0] run_mode;
  ctl_cmd_t   cmd;
  dp_stat_t   stat;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {30'd0, run_mode} : 32'd0;

  // The only register is the run mode; other addresses are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      run_mode <= MODE_AUTO;
    end else if (psel && penable && pwrite && paddr == 2'(RegRunMode * 4)) begin
      run_mode <= pwdata[1:0];
    end
  end

  rsac_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .run_mode(run_mode), .stat(stat), .cmd(cmd)
  );

  rsac_datapath u_dp (
    .clk(clk), .rst(rst), .in_data(in_ch.data), .run_mode(run_mode),
    .cmd(cmd), .stat(stat), .out_ch(out_ch)
  );
endmodule
